FILE: rtl/core/lvat_pkg.sv
package lvat_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int RADIUS     = 3;
   localparam int WIN        = 2 * RADIUS + 1;
   localparam int LINES      = WIN - 1;

   localparam int PIX_W  = 8;
   localparam int GEOM_W = 11;
   localparam int THR_W  = 15;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * WIN);
   localparam int LAG_W  = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

   localparam int CNT_W  = $clog2(WIN + 1);
   localparam int CSUM_W = PIX_W + CNT_W;
   localparam int CSQ_W  = 2 * PIX_W + CNT_W;
   localparam int N_W    = $clog2(WIN * WIN + 1);
   localparam int WSUM_W = PIX_W + N_W;
   localparam int WSQ_W  = 2 * PIX_W + N_W;
   localparam int DEV_W  = WSUM_W + 1;
   localparam int PROD_W = PIX_W + DEV_W;
   localparam int THRN_W = THR_W + N_W;
   localparam int QBIT_W = $clog2(PIX_W);

   localparam logic [GEOM_W-1:0] WIDTH_RST  = GEOM_W'(256);
   localparam logic [GEOM_W-1:0] HEIGHT_RST = GEOM_W'(256);
   localparam logic [THR_W-1:0]  THRESH_RST = THR_W'(1000);

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_THRESH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SUM,
      ST_DIV,
      ST_VAR,
      ST_DEV,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [CSUM_W-1:0] csum;
      logic [CSQ_W-1:0]  csq;
      logic [CNT_W-1:0]  cnt;
      logic [PIX_W-1:0]  center;
   } col_stat_type;

endpackage

FILE: rtl/core/lvat_if.sv
interface lvat_req_if;
   import lvat_pkg::*;
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, req_type, pixel, input ready);
   modport sink (input valid, req_type, pixel, output ready);
endinterface

interface lvat_rsp_if;
   logic valid;
   logic ready;
   logic white;
   logic frame_last;
   modport source (output valid, white, frame_last, input ready);
   modport sink (input valid, white, frame_last, output ready);
endinterface

FILE: rtl/core/lvat_line_cell.sv
module lvat_line_cell
   import lvat_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic             wr_en,
   input  logic [COL_W-1:0] addr,
   input  logic [PIX_W-1:0] wr_data,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lvat_col_cell.sv
module lvat_col_cell
   import lvat_pkg::*;
(
   input  logic         clock,
   input  logic         shift,
   input  col_stat_type push_stat,
   output col_stat_type stat
);

   col_stat_type stat_ff;
   col_stat_type stat_in;

   always_comb begin
      stat_in = shift ? push_stat : stat_ff;
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
   end

   assign stat = stat_ff;

endmodule

FILE: rtl/core/lvat_div.sv
module lvat_div
   import lvat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WSUM_W-1:0] dividend,
   input  logic [N_W-1:0]    divisor,
   output logic              done,
   output logic [PIX_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QBIT_W-1:0] bit_ff, bit_in;
   logic [WSUM_W-1:0] rem_ff, rem_in;
   logic [N_W-1:0]    dvs_ff, dvs_in;
   logic [PIX_W-1:0]  quot_ff, quot_in;
   logic [WSUM_W-1:0] trial;

   // quotient fits in PIX_W bits, so only those bit positions are tried
   always_comb begin
      trial   = WSUM_W'(dvs_ff) << bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = QBIT_W'(PIX_W - 1);
         rem_in  = dividend;
         dvs_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in          = rem_ff - trial;
            quot_in[bit_ff] = 1'b1;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/core/local_variance_adaptive_threshold_core.sv
// Binarises an 8-bit gray raster stream against the mean and variance of each
// pixel's 7x7 neighbourhood, clipped at the frame edges. Six line memories
// form a chain of row delays, and a row of seven column cells carries the
// per-column sum, sum of squares and in-frame count across the window. An
// item that gives no result passes through a line read and then a shift; one
// that gives a result also passes the 8-step serial divider that forms the
// mean and the two multiply stages of the variance test. A flush beat inside
// the frame is dropped. Results trail the input by 3*width+3 beats; send flush
// beats after the frame to drain them. Writing width or height restarts the
// frame. The line memories need no clearing after reset.
module local_variance_adaptive_threshold_core
   import lvat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   lvat_req_if.sink          req,
   lvat_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   state_type state_ff, state_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [LAG_W-1:0]  lead_ff, lead_in;
   logic [COL_W-1:0]  ox_ff, ox_in;
   logic [ROW_W-1:0]  oy_ff, oy_in;
   logic [GEOM_W-1:0] width_ff, width_in;
   logic [GEOM_W-1:0] height_ff, height_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [COL_W-1:0]  addr_ff, addr_in;
   logic [ROW_W-1:0]  rowk_ff, rowk_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [WSUM_W-1:0] sum_ff, sum_in;
   logic [WSQ_W-1:0]  sq_ff, sq_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [PIX_W-1:0]  ctr_ff, ctr_in;
   logic              last_ff, last_in;
   logic [DEV_W-1:0]  t_ff, t_in;
   logic [WSQ_W-1:0]  dev_ff, dev_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              white_ff, white_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [GEOM_W-1:0] eff_w, eff_h;
   logic [LAG_W-1:0]  lag;
   logic [COL_W-1:0]  col_cur;
   logic [COL_W-1:0]  mem_addr;
   logic              rd_en, wr_en, shift, div_start, div_done;
   logic [PIX_W-1:0]  mean;
   logic [PIX_W-1:0]  tap [WIN];
   col_stat_type      win [WIN];
   col_stat_type      push [WIN];
   col_stat_type      new_stat;
   logic [WSUM_W-1:0] win_sum;
   logic [WSQ_W-1:0]  win_sq;
   logic [N_W-1:0]    win_n;
   logic [N_W-1:0]    div_n;
   logic [THRN_W-1:0] thr_n;
   logic              cfg_wr;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = GEOM_W'(1);
      end else if (width_ff > GEOM_W'(MAX_WIDTH)) begin
         eff_w = GEOM_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = GEOM_W'(1);
      end else if (height_ff > GEOM_W'(MAX_HEIGHT)) begin
         eff_h = GEOM_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
      lag     = LAG_W'(eff_w) * LAG_W'(RADIUS) + LAG_W'(RADIUS);
      col_cur = (GEOM_W'(col_ff) >= eff_w) ? '0 : col_ff;
   end

   // read the incoming column at the accept cycle, write it back in the shift
   assign mem_addr = rd_en ? col_cur : addr_ff;

   // row delay chain: tap i holds row (current - i) at the current column
   assign tap[0] = pix_ff;

   for (genvar i = 1; i < WIN; i++) begin : g_line
      lvat_line_cell u_line (
         .clock   (clock),
         .rd_en   (rd_en),
         .wr_en   (wr_en),
         .addr    (mem_addr),
         .wr_data (tap[i-1]),
         .rd_data (tap[i])
      );
   end

   // fold the entering column, dropping rows outside the frame
   always_comb begin
      logic ok;
      new_stat        = '0;
      new_stat.col    = addr_ff;
      new_stat.center = tap[RADIUS];
      for (int i = 0; i < WIN; i++) begin
         ok = (rowk_ff >= ROW_W'(i)) && ((rowk_ff - ROW_W'(i)) < ROW_W'(eff_h));
         if (ok) begin
            new_stat.csum = new_stat.csum + CSUM_W'(tap[i]);
            new_stat.csq  = new_stat.csq + CSQ_W'(tap[i]) * CSQ_W'(tap[i]);
            new_stat.cnt  = new_stat.cnt + 1'b1;
         end
      end
   end

   for (genvar j = 0; j < WIN; j++) begin : g_col
      if (j == WIN - 1) begin : g_head
         assign push[j] = new_stat;
      end else begin : g_body
         assign push[j] = win[j+1];
      end
      lvat_col_cell u_col (
         .clock     (clock),
         .shift     (shift),
         .push_stat (push[j]),
         .stat      (win[j])
      );
   end

   // a column counts only when it lies in the centre's row, at its offset
   always_comb begin
      logic incl;
      win_sum = '0;
      win_sq  = '0;
      win_n   = '0;
      for (int j = 0; j < WIN; j++) begin
         incl = (({1'b0, win[j].col} + (COL_W+1)'(RADIUS))
                 == ({1'b0, win[RADIUS].col} + (COL_W+1)'(j)));
         if (incl) begin
            win_sum = win_sum + WSUM_W'(win[j].csum);
            win_sq  = win_sq + WSQ_W'(win[j].csq);
            win_n   = win_n + N_W'(win[j].cnt);
         end
      end
      div_n = (win_n == '0) ? N_W'(1) : win_n;
   end

   lvat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum),
      .divisor  (div_n),
      .done     (div_done),
      .quotient (mean)
   );

   assign thr_n  = THRN_W'(thr_ff) * THRN_W'(n_ff);
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lead_in      = lead_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      thr_in       = thr_ff;
      addr_in      = addr_ff;
      rowk_in      = rowk_ff;
      pix_in       = pix_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      n_in         = n_ff;
      ctr_in       = ctr_ff;
      last_in      = last_ff;
      t_in         = t_ff;
      dev_in       = dev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      white_in     = white_ff;
      rsp_last_in  = rsp_last_ff;
      req.ready    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      shift        = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if ((GEOM_W'(row_ff) < eff_h) && req.req_type) begin
                  // flush inside the frame: drop it
                  col_in = col_cur;
               end else begin
                  rd_en   = 1'b1;
                  addr_in = col_cur;
                  rowk_in = row_ff;
                  pix_in  = req.pixel;
                  if (GEOM_W'(col_cur) + 1'b1 >= eff_w) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_cur + 1'b1;
                  end
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            wr_en    = 1'b1;
            shift    = 1'b1;
            state_in = ST_IDLE;
            if (lead_ff != lag) begin
               lead_in = lead_ff + 1'b1;
            end else if (GEOM_W'(oy_ff) >= eff_h) begin
               col_in  = '0;
               row_in  = '0;
               lead_in = '0;
               ox_in   = '0;
               oy_in   = '0;
            end else begin
               last_in = (GEOM_W'(ox_ff) == eff_w - 1'b1)
                         && (GEOM_W'(oy_ff) == eff_h - 1'b1);
               if (last_in) begin
                  col_in  = '0;
                  row_in  = '0;
                  lead_in = '0;
                  ox_in   = '0;
                  oy_in   = '0;
               end else if (GEOM_W'(ox_ff) + 1'b1 >= eff_w) begin
                  ox_in = '0;
                  oy_in = oy_ff + 1'b1;
               end else begin
                  ox_in = ox_ff + 1'b1;
               end
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in    = win_sum;
            sq_in     = win_sq;
            n_in      = div_n;
            ctr_in    = win[RADIUS].center;
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            // sum of squared deviations = sq - mean * (2*sum - n*mean)
            t_in     = DEV_W'({sum_ff, 1'b0}) - DEV_W'(n_ff) * DEV_W'(mean);
            state_in = ST_DEV;
         end
         ST_DEV: begin
            dev_in   = WSQ_W'(PROD_W'(sq_ff) - PROD_W'(mean) * PROD_W'(t_ff));
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               white_in     = (dev_ff >= WSQ_W'(thr_n)) ? (ctr_ff >= mean) : 1'b1;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         case (paddr[3:2])
            REG_WIDTH: begin
               width_in = pwdata[GEOM_W-1:0];
               col_in   = '0;
               row_in   = '0;
               lead_in  = '0;
               ox_in    = '0;
               oy_in    = '0;
            end
            REG_HEIGHT: begin
               height_in = pwdata[GEOM_W-1:0];
               col_in    = '0;
               row_in    = '0;
               lead_in   = '0;
               ox_in     = '0;
               oy_in     = '0;
            end
            REG_THRESH: begin
               thr_in = pwdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         lead_ff      <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
         thr_ff       <= THRESH_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lead_ff      <= lead_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      rowk_ff     <= rowk_in;
      pix_ff      <= pix_in;
      sum_ff      <= sum_in;
      sq_ff       <= sq_in;
      n_ff        <= n_in;
      ctr_ff      <= ctr_in;
      last_ff     <= last_in;
      t_ff        <= t_in;
      dev_ff      <= dev_in;
      white_ff    <= white_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         REG_THRESH: prdata = DATA_W'(thr_ff);
         default:    prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.white      = white_ff;
   assign rsp.frame_last = rsp_last_ff;

endmodule

FILE: rtl/core/lvat_checker.sv
module lvat_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_white,
   input logic rsp_frame_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_white) && $stable(rsp_frame_last))
      else $error("stalled result beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while input side was idle");

endmodule

bind local_variance_adaptive_threshold_core lvat_checker u_lvat_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_white      (rsp.white),
   .rsp_frame_last (rsp.frame_last)
);

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import lvat_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING        = WIN * MAX_WIDTH + WIN;
   localparam int LAG_WAIT    = 40;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic white;
      logic frame_last;
   } bin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   lvat_req_if req_bus ();
   lvat_rsp_if rsp_bus ();

   local_variance_adaptive_threshold_core dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // shadow of the block's state
   logic [PIX_W-1:0]  pix_ring [RING];
   int unsigned       pos_col, pos_row;
   logic [GEOM_W-1:0] width_q, height_q;
   logic [THR_W-1:0]  thresh_q;
   bit                frame_wrapped;

   bin_result_type    bin_expected [$];
   int                failures = 0;
   int                items_sent = 0;
   bit                no_idle = 0;
   bit                hold_req = 0;

   function automatic int unsigned used_width();
      if (width_q == 0) return 1;
      if (width_q > MAX_WIDTH) return MAX_WIDTH;
      return width_q;
   endfunction

   function automatic int unsigned used_height();
      if (height_q == 0) return 1;
      if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
      return height_q;
   endfunction

   function automatic int unsigned ring_pix(int unsigned w, int unsigned y, int unsigned x);
      return pix_ring[(y * w + x) % RING];
   endfunction

   function automatic logic binarise(int unsigned w, int unsigned h,
                                     int unsigned y, int unsigned x);
      int unsigned sum, n, mean, sq, v, d;
      int yy, xx;
      sum = 0;
      n = 0;
      sq = 0;
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            yy = int'(y) + dy;
            xx = int'(x) + dx;
            if (yy >= 0 && yy < int'(h) && xx >= 0 && xx < int'(w)) begin
               sum += ring_pix(w, yy, xx);
               n++;
            end
         end
      end
      if (n == 0) n = 1;
      mean = sum / n;
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            yy = int'(y) + dy;
            xx = int'(x) + dx;
            if (yy >= 0 && yy < int'(h) && xx >= 0 && xx < int'(w)) begin
               v = ring_pix(w, yy, xx);
               d = (v >= mean) ? v - mean : mean - v;
               sq += d * d;
            end
         end
      end
      if (sq / n >= thresh_q) return ring_pix(w, y, x) >= mean;
      return 1'b1;
   endfunction

   task automatic predict_beat(input logic flush, input logic [PIX_W-1:0] pix);
      int unsigned w, h, total, lag, k, p;
      bin_result_type res;
      w = used_width();
      h = used_height();
      total = w * h;
      lag = RADIUS * w + RADIUS;
      if (pos_col >= w) pos_col = 0;
      k = pos_row * w + pos_col;
      if (k < total) begin
         if (flush) return;
         pix_ring[k % RING] = pix;
      end
      items_sent++;
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (k < lag) return;
      p = k - lag;
      if (p >= total) begin
         pos_col = 0;
         pos_row = 0;
         frame_wrapped = 1;
         return;
      end
      res.white = binarise(w, h, p / w, p % w);
      res.frame_last = (p == total - 1);
      bin_expected.push_back(res);
      if (res.frame_last) begin
         pos_col = 0;
         pos_row = 0;
         frame_wrapped = 1;
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_WIDTH: begin
            width_q = value[GEOM_W-1:0];
            pos_col = 0;
            pos_row = 0;
         end
         REG_HEIGHT: begin
            height_q = value[GEOM_W-1:0];
            pos_col = 0;
            pos_row = 0;
         end
         REG_THRESH: thresh_q = value[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_beat(input logic flush, input logic [PIX_W-1:0] pix);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= flush;
      req_bus.pixel <= pix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_beat(flush, pix);
   endtask

   // wait for the last result, then let any flush beat still in work finish
   task automatic settle();
      @(posedge clock);
      req_bus.valid <= 1'b0;
      while (bin_expected.size() != 0) @(posedge clock);
      repeat (LAG_WAIT) @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int thr);
      settle();
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_THRESH, thr);
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input int mode, input int base);
      case (mode)
         0: return PIX_W'($urandom_range(0, 255));
         1: return PIX_W'(base + $urandom_range(0, 12));
         default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // feed stop_at pixels and stop there, or feed all of them when negative and
   // then flush until the frame wraps
   task automatic send_frame(input int stop_at, input int noise_pct);
      int unsigned total;
      int mode, base;
      total = used_width() * used_height();
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 243);
      frame_wrapped = 0;
      for (int i = 0; i < total; i++) begin
         if (stop_at >= 0 && i >= stop_at) return;
         if ($urandom_range(0, 99) < noise_pct)
            send_beat(1'b1, PIX_W'($urandom_range(0, 255)));
         send_beat(1'b0, pick_pixel(mode, base));
      end
      while (!frame_wrapped) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_beat(1'b0, PIX_W'($urandom_range(0, 255)));
         else send_beat(1'b1, PIX_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_single_pixel();
      configure(1, 1, 0);
      send_beat(1'b0, 8'hFF);
      while (!frame_wrapped) send_beat(1'b1, 8'h00);
      configure(0, 0, 16384);
      frame_wrapped = 0;
      send_beat(1'b1, 8'h00);
      send_beat(1'b0, 8'h00);
      while (!frame_wrapped) send_beat(1'b0, 8'hA5);
   endtask

   task automatic test_small_extremes();
      logic [PIX_W-1:0] pat [9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80,
                                    8'hFF, 8'h00, 8'hFF, 8'h01};
      configure(3, 3, 0);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      frame_wrapped = 0;
      foreach (pat[i]) begin
         if (i == 4) send_beat(1'b1, 8'hFF);
         send_beat(1'b0, pat[i]);
      end
      while (!frame_wrapped) send_beat(1'b1, 8'h00);
      configure(3, 3, 32767);
      send_frame(-1, 20);
   endtask

   task automatic test_geometry_restart();
      configure(5, 4, 200);
      send_frame(14, 10);
      settle();
      csr_write(REG_WIDTH, 4);
      send_frame(-1, 10);
      send_frame(9, 0);
      settle();
      csr_write(REG_HEIGHT, 2);
      send_frame(-1, 0);
   endtask

   // oversized geometry, cut short and restarted by the next write
   task automatic test_wide_and_tall();
      configure(2047, 2, $urandom_range(0, 3000));
      send_frame(40, 2);
      configure(1, 2047, $urandom_range(0, 3000));
      send_frame(60, 2);
   endtask

   task automatic test_backpressure();
      configure(6, 6, 300);
      no_idle = 1;
      hold_req = 1;
      send_frame(-1, 0);
      no_idle = 0;
   endtask

   task automatic test_random_frames();
      int thr, stop_at;
      while (items_sent < 600) begin
         case ($urandom_range(0, 5))
            0: thr = 0;
            1: thr = 16384;
            2: thr = $urandom_range(0, 32767);
            default: thr = $urandom_range(0, 3000);
         endcase
         configure($urandom_range(1, 12), $urandom_range(1, 6), thr);
         stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : -1;
         no_idle = ($urandom_range(0, 4) == 0);
         send_frame(stop_at, $urandom_range(0, 1) ? 0 : 15);
      end
      no_idle = 0;
   endtask

   // result side: check each beat, then choose the next ready
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      bin_result_type got, want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         got.white = rsp_bus.white;
         got.frame_last = rsp_bus.frame_last;
         if (bin_expected.size() == 0) begin
            $display("%0t: unexpected result white=%0b frame_last=%0b",
                     $time, got.white, got.frame_last);
            failures++;
         end else begin
            want = bin_expected.pop_front();
            if (got.white !== want.white) begin
               $display("%0t: white expected %0b actual %0b", $time, want.white, got.white);
               failures++;
            end
            if (got.frame_last !== want.frame_last) begin
               $display("%0t: frame_last expected %0b actual %0b",
                        $time, want.frame_last, got.frame_last);
               failures++;
            end
         end
      end
      if (hold_req) begin
         hold_req = 0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) stall_left = gap_len();
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = 1'b0;
      req_bus.pixel = '0;
      foreach (pix_ring[i]) pix_ring[i] = '0;
      pos_col = 0;
      pos_row = 0;
      width_q = WIDTH_RST;
      height_q = HEIGHT_RST;
      thresh_q = THRESH_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_single_pixel();
      test_small_extremes();
      test_geometry_restart();
      test_backpressure();
      test_wide_and_tall();
      test_random_frames();
      settle();
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
